FILE: sv/clas_pkg.sv
// Shared types and constants for the command line argument splitter.
// Used by clas_decode and command_line_argument_splitter_unit; no dependencies.
package clas_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int ARG_W       = 16;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_BLANK  = 8'h20;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [1:0] {
    KIND_CHAR     = 2'd0,
    KIND_END_ARG  = 2'd1,
    KIND_END_LINE = 2'd2
  } kind_t;

  typedef struct packed {
    logic                   in_arg;
    logic                   in_quote;
    logic                   held;
    logic                   held_after_bs;
    logic                   prev_bs;
    logic [COUNT_WIDTH-1:0] count;
  } tok_state_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       ch;
    logic [ARG_W-1:0] count;
  } res_t;

endpackage

FILE: sv/command_line_argument_splitter_unit.sv
// Top level of the command line argument splitter: state, run buffer, handshakes.
// Depends on clas_pkg and clas_decode.
//
//  channel | signals                                         | dir | beat
//  --------+-------------------------------------------------+-----+--------------------------
//  in      | in_valid, in_stall, in_byte                     | in  | one raw line byte
//  out     | out_valid, out_stall, kind, out_char, arg_count, | out | one result
//          | last_of_run                                     |     |
//  cfg     | cfg_valid, cfg_ready, emit_chars                | in  | emit_chars register write
//
// A byte is decoded in the cycle it is accepted; its results land in a three-entry
// run buffer and leave one beat per cycle while out_stall is low, starting the next cycle.
// A byte giving results holds the input while they leave the run buffer; the run buffer
// drain is the limit, so a new byte is taken in the cycle the last beat leaves.
// Reset (rst, synchronous) clears the tokenizer state, empties the run buffer and
// sets emit_chars to 1. out_stall holds the current beat; in_stall follows it.
module command_line_argument_splitter_unit import clas_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       kind,
  output logic [7:0]       out_char,
  output logic [ARG_W-1:0] arg_count,
  output logic             last_of_run,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             emit_chars
);

  tok_state_t st;
  tok_state_t st_next;
  res_t       dec_res [3];
  logic [1:0] dec_cnt;
  res_t       run [3];
  logic [1:0] run_rem;
  logic       emit_reg;
  logic       accept;
  logic       take;

  clas_decode u_decode (
    .st         (st),
    .in_byte    (in_byte),
    .emit_chars (emit_reg),
    .st_next    (st_next),
    .res        (dec_res),
    .res_cnt    (dec_cnt)
  );

  assign cfg_ready   = 1'b1;
  assign out_valid   = (run_rem != 2'd0);
  assign take        = out_valid && !out_stall;
  assign in_stall    = (run_rem > 2'd1) || (run_rem == 2'd1 && out_stall);
  assign accept      = in_valid && !in_stall;

  assign kind        = run[0].kind;
  assign out_char    = run[0].ch;
  assign arg_count   = run[0].count;
  assign last_of_run = (run_rem == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_reg <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      emit_reg <= emit_chars;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_rem <= 2'd0;
    end else if (accept) begin
      run_rem <= dec_cnt;
    end else if (take) begin
      run_rem <= run_rem - 2'd1;
    end
  end

  // load a fresh run, or advance the buffer by one beat
  always_ff @(posedge clk) begin
    if (accept) begin
      run <= dec_res;
    end else if (take) begin
      run[0] <= run[1];
      run[1] <= run[2];
    end
  end

  a_nul_clears_count: assert property (@(posedge clk) disable iff (rst)
    accept && in_byte == CH_NUL |=> st.count == '0 && !st.in_arg && !st.held)
    else $error("state not cleared after end of line");

  a_count_holds: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(st.count))
    else $error("argument count moved without an input beat");

  a_quote_in_arg: assert property (@(posedge clk) disable iff (rst)
    st.in_quote |-> st.in_arg)
    else $error("quoting outside an argument");

  a_held_prev: assert property (@(posedge clk) disable iff (rst)
    st.held |-> st.prev_bs)
    else $error("held backslash without backslash lookbehind");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    take && run_rem == 2'd1 && !accept |=> !out_valid)
    else $error("run buffer did not empty after its last beat");

endmodule

FILE: sv/clas_decode.sv
// Per-byte decode: next tokenizer state and up to three results for one byte.
// Depends on clas_pkg.
module clas_decode import clas_pkg::*; (
  input  tok_state_t st,
  input  logic [7:0] in_byte,
  input  logic       emit_chars,
  output tok_state_t st_next,
  output res_t       res [3],
  output logic [1:0] res_cnt
);

  always_comb begin
    logic blank;
    logic done;
    logic [1:0] n;
    tok_state_t s;

    blank = (in_byte == CH_BLANK) || (in_byte == CH_TAB);
    done  = 1'b0;
    n     = 2'd0;
    s     = st;
    for (int i = 0; i < 3; i++) begin
      res[i] = '{kind: KIND_CHAR, ch: 8'h00, count: '0};
    end

    // held backslash resolves against this byte
    if (s.held) begin
      s.held = 1'b0;
      if (in_byte == CH_QUOTE) begin
        if (s.held_after_bs) begin
          s.in_quote = ~s.in_quote;
        end else if (emit_chars) begin
          res[n] = '{kind: KIND_CHAR, ch: CH_QUOTE, count: ARG_W'(s.count)};
          n = n + 2'd1;
        end
        done = 1'b1;
      end else if (emit_chars) begin
        res[n] = '{kind: KIND_CHAR, ch: CH_BSLASH, count: ARG_W'(s.count)};
        n = n + 2'd1;
      end
    end

    if (!done && !s.in_arg) begin
      if (blank) begin
        done = 1'b1;
      end else if (in_byte == CH_NUL) begin
        res[n] = '{kind: KIND_END_LINE, ch: 8'h00, count: ARG_W'(s.count)};
        n = n + 2'd1;
        done = 1'b1;
      end else begin
        s.in_arg = 1'b1;
      end
    end

    if (!done) begin
      if (in_byte == CH_QUOTE) begin
        s.in_quote = ~s.in_quote;
      end else if ((blank && !s.in_quote) || in_byte == CH_NUL) begin
        // close the argument; count saturates
        if (s.count != '1) begin
          s.count = s.count + 1'b1;
        end
        s.in_arg   = 1'b0;
        s.in_quote = 1'b0;
        res[n] = '{kind: KIND_END_ARG, ch: 8'h00, count: ARG_W'(s.count)};
        n = n + 2'd1;
        if (in_byte == CH_NUL) begin
          res[n] = '{kind: KIND_END_LINE, ch: 8'h00, count: ARG_W'(s.count)};
          n = n + 2'd1;
        end
      end else if (in_byte == CH_BSLASH) begin
        s.held          = 1'b1;
        s.held_after_bs = s.prev_bs;
      end else if (emit_chars) begin
        res[n] = '{kind: KIND_CHAR, ch: in_byte, count: ARG_W'(s.count)};
        n = n + 2'd1;
      end
    end

    s.prev_bs = (in_byte == CH_BSLASH);

    // end of line: back to reset state
    if (in_byte == CH_NUL) begin
      s = '0;
    end

    st_next = s;
    res_cnt = n;
  end

endmodule
